@@ src/lrq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrq_pkg: shared constants and types for the look rotation quaternion block
// Fixed-point formats, pipeline depths of the normalizer and lane types.
// ----------------------------------------------------------------------------
package lrq_pkg;

  localparam int COORD_WIDTH    = 32;  // input coordinate width, Q16.16 at 32
  localparam int QUAT_FRAC_BITS = 15;  // output fraction bits

  localparam int UNIT_BITS = 30;       // unit vectors are Q2.30
  localparam int UP_BITS   = 29;       // up hint only needs block scaling
  localparam int VEC_W     = 64;       // normalizer input lane width
  localparam int NLANE     = 4;
  localparam int C_W       = 31;       // block-scaled component, |c| <= 2^30
  localparam int SQ_W      = 62;       // square of a scaled component
  localparam int LEN_W     = 32;       // vector length, <= 2^31
  localparam int Q_W       = 32;       // normalized lane, |q| <= 2^30
  localparam int SH_W      = $clog2(VEC_W);
  localparam int FB_W      = 5;

  localparam int SQ_ITERS  = VEC_W / 2;
  localparam int SQ_PER    = 2;
  localparam int SQ_STAGES = SQ_ITERS / SQ_PER;
  localparam int DV_ITERS  = LEN_W;
  localparam int DV_PER    = 4;
  localparam int DV_STAGES = DV_ITERS / DV_PER;

  // abs/max, shift search, shift, square, sum, root, numerator, divide, sign
  localparam int NORM_LAT = 5 + SQ_STAGES + 1 + DV_STAGES + 1;

  typedef logic signed [VEC_W-1:0] wide_t;
  typedef logic signed [C_W-1:0]   cval_t;
  typedef logic signed [Q_W-1:0]   nq_t;

  typedef struct packed {
    logic vld;
    logic ok;
  } stat_t;

endpackage

@@ src/look_rotation_quaternion.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_rotation_quaternion: orientation quaternion from forward and up
// Normalizes forward, forms right and the re-derived up, converts the basis
// to a quaternion by the four-branch trace method and normalizes it.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | fwd_x..z, up_x..z (Q16.16)
//   out_    | output    | out_valid/out_stall| quat_w..z (Q1.15), degenerate
//
// One item per cycle enters while the output is not held; results pass
// through three normalizers in series, each with a root and a divide
// pipeline. The whole pipeline advances on one enable, so a held output
// freezes every stage and in_stall follows out_stall.
// rst_n clears the valid bits only.
module look_rotation_quaternion (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [lrq_pkg::COORD_WIDTH-1:0] in_fwd_x,
  input  logic signed [lrq_pkg::COORD_WIDTH-1:0] in_fwd_y,
  input  logic signed [lrq_pkg::COORD_WIDTH-1:0] in_fwd_z,
  input  logic signed [lrq_pkg::COORD_WIDTH-1:0] in_up_x,
  input  logic signed [lrq_pkg::COORD_WIDTH-1:0] in_up_y,
  input  logic signed [lrq_pkg::COORD_WIDTH-1:0] in_up_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lrq_pkg::QUAT_FRAC_BITS:0] out_quat_w,
  output logic signed [lrq_pkg::QUAT_FRAC_BITS:0] out_quat_x,
  output logic signed [lrq_pkg::QUAT_FRAC_BITS:0] out_quat_y,
  output logic signed [lrq_pkg::QUAT_FRAC_BITS:0] out_quat_z,
  output logic                                 out_degenerate
);
  import lrq_pkg::*;

  localparam int PAD = VEC_W - COORD_WIDTH;
  localparam int U_W = 34;
  localparam int T_W = 36;
  localparam int OW  = QUAT_FRAC_BITS + 1;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  localparam logic signed [T_W-1:0] ONE_T = T_W'(1) << UNIT_BITS;
  localparam logic signed [Q_W-1:0] QMAX  = Q_W'((1 << QUAT_FRAC_BITS) - 1);
  localparam logic signed [Q_W-1:0] QMIN  = -(Q_W'(1) << QUAT_FRAC_BITS);

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // forward and up normalizers
  wide_t fwd_v [NLANE];
  wide_t up_v  [NLANE];
  stat_t f_stat, u_stat;
  nq_t   f_n [NLANE];
  nq_t   u_n [NLANE];

  assign fwd_v[0] = {{PAD{in_fwd_x[COORD_WIDTH-1]}}, in_fwd_x};
  assign fwd_v[1] = {{PAD{in_fwd_y[COORD_WIDTH-1]}}, in_fwd_y};
  assign fwd_v[2] = {{PAD{in_fwd_z[COORD_WIDTH-1]}}, in_fwd_z};
  assign fwd_v[3] = '0;
  assign up_v[0]  = {{PAD{in_up_x[COORD_WIDTH-1]}}, in_up_x};
  assign up_v[1]  = {{PAD{in_up_y[COORD_WIDTH-1]}}, in_up_y};
  assign up_v[2]  = {{PAD{in_up_z[COORD_WIDTH-1]}}, in_up_z};
  assign up_v[3]  = '0;

  lrq_norm u_norm_f (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_vld(in_valid),
    .fb    (FB_W'(UNIT_BITS)),
    .vin   (fwd_v),
    .stat  (f_stat),
    .qout  (f_n)
  );

  lrq_norm u_norm_u (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_vld(in_valid),
    .fb    (FB_W'(UP_BITS)),
    .vin   (up_v),
    .stat  (u_stat),
    .qout  (u_n)
  );

  // right = up x forward
  wide_t x1_p_r [6];
  nq_t   x1_f_r [3];
  logic  x1_ok_r, x1_vld_r;
  wide_t x2_rc_r [NLANE];
  nq_t   x2_f_r [3];
  logic  x2_ok_r, x2_vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_p_r[0] <= VEC_W'(u_n[1]) * VEC_W'(f_n[2]);
      x1_p_r[1] <= VEC_W'(u_n[2]) * VEC_W'(f_n[1]);
      x1_p_r[2] <= VEC_W'(u_n[2]) * VEC_W'(f_n[0]);
      x1_p_r[3] <= VEC_W'(u_n[0]) * VEC_W'(f_n[2]);
      x1_p_r[4] <= VEC_W'(u_n[0]) * VEC_W'(f_n[1]);
      x1_p_r[5] <= VEC_W'(u_n[1]) * VEC_W'(f_n[0]);
      for (int i = 0; i < 3; i++) x1_f_r[i] <= f_n[i];
      x1_ok_r    <= f_stat.ok && u_stat.ok;
      x2_rc_r[0] <= x1_p_r[0] - x1_p_r[1];
      x2_rc_r[1] <= x1_p_r[2] - x1_p_r[3];
      x2_rc_r[2] <= x1_p_r[4] - x1_p_r[5];
      x2_rc_r[3] <= '0;
      x2_f_r     <= x1_f_r;
      x2_ok_r    <= x1_ok_r;
    end
  end

  stat_t r_stat;
  nq_t   r_n [NLANE];

  lrq_norm u_norm_r (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_vld(x2_vld_r),
    .fb    (FB_W'(UNIT_BITS)),
    .vin   (x2_rc_r),
    .stat  (r_stat),
    .qout  (r_n)
  );

  // carry forward alongside the right-vector normalizer
  nq_t  dl_f_r  [NORM_LAT][3];
  logic dl_ok_r [NORM_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      dl_f_r[0]  <= x2_f_r;
      dl_ok_r[0] <= x2_ok_r;
      for (int k = 1; k < NORM_LAT; k++) begin
        dl_f_r[k]  <= dl_f_r[k-1];
        dl_ok_r[k] <= dl_ok_r[k-1];
      end
    end
  end

  // up = forward x right, then matrix trace and branch
  wide_t y1_p_r [6];
  nq_t   y1_f_r [3];
  nq_t   y1_r_r [3];
  logic  y1_ok_r, y1_vld_r;

  wide_t ud_y2 [3];
  logic signed [U_W-1:0] y2_u_r [3];
  nq_t   y2_f_r [3];
  nq_t   y2_r_r [3];
  logic  y2_ok_r, y2_vld_r;

  logic signed [T_W-1:0] r0_e, u1_e, f2_e, t_y3;
  logic [1:0]            br_y3;
  logic [1:0]            y3_br_r;
  logic signed [T_W-1:0] y3_t_r;
  logic signed [T_W-1:0] y3_u_r [3];
  logic signed [T_W-1:0] y3_f_r [3];
  logic signed [T_W-1:0] y3_r_r [3];
  logic                  y3_ok_r, y3_vld_r;

  logic signed [T_W-1:0] qv_y4 [NLANE];
  wide_t                 y4_qv_r [NLANE];
  logic                  y4_ok_r, y4_vld_r;

  always_comb begin
    ud_y2[0] = (y1_p_r[0] - y1_p_r[1]) >>> UNIT_BITS;
    ud_y2[1] = (y1_p_r[2] - y1_p_r[3]) >>> UNIT_BITS;
    ud_y2[2] = (y1_p_r[4] - y1_p_r[5]) >>> UNIT_BITS;
  end

  always_comb begin
    r0_e = T_W'(y2_r_r[0]);
    u1_e = T_W'(y2_u_r[1]);
    f2_e = T_W'(y2_f_r[2]);
    t_y3 = r0_e + u1_e + f2_e;
    if (t_y3 > 0) begin
      br_y3 = BR_TRACE;
    end else if (r0_e >= u1_e && r0_e >= f2_e) begin
      br_y3 = BR_X;
    end else if (u1_e > f2_e) begin
      br_y3 = BR_Y;
    end else begin
      br_y3 = BR_Z;
    end
  end

  always_comb begin
    case (y3_br_r)
      BR_TRACE: begin
        qv_y4[0] = ONE_T + y3_t_r;
        qv_y4[1] = y3_u_r[2] - y3_f_r[1];
        qv_y4[2] = y3_f_r[0] - y3_r_r[2];
        qv_y4[3] = y3_r_r[1] - y3_u_r[0];
      end
      BR_X: begin
        qv_y4[0] = y3_u_r[2] - y3_f_r[1];
        qv_y4[1] = ONE_T + y3_r_r[0] - y3_u_r[1] - y3_f_r[2];
        qv_y4[2] = y3_r_r[1] + y3_u_r[0];
        qv_y4[3] = y3_r_r[2] + y3_f_r[0];
      end
      BR_Y: begin
        qv_y4[0] = y3_f_r[0] - y3_r_r[2];
        qv_y4[1] = y3_u_r[0] + y3_r_r[1];
        qv_y4[2] = ONE_T + y3_u_r[1] - y3_r_r[0] - y3_f_r[2];
        qv_y4[3] = y3_f_r[1] + y3_u_r[2];
      end
      default: begin
        qv_y4[0] = y3_r_r[1] - y3_u_r[0];
        qv_y4[1] = y3_f_r[0] + y3_r_r[2];
        qv_y4[2] = y3_f_r[1] + y3_u_r[2];
        qv_y4[3] = ONE_T + y3_f_r[2] - y3_r_r[0] - y3_u_r[1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1_p_r[0] <= VEC_W'(dl_f_r[NORM_LAT-1][1]) * VEC_W'(r_n[2]);
      y1_p_r[1] <= VEC_W'(dl_f_r[NORM_LAT-1][2]) * VEC_W'(r_n[1]);
      y1_p_r[2] <= VEC_W'(dl_f_r[NORM_LAT-1][2]) * VEC_W'(r_n[0]);
      y1_p_r[3] <= VEC_W'(dl_f_r[NORM_LAT-1][0]) * VEC_W'(r_n[2]);
      y1_p_r[4] <= VEC_W'(dl_f_r[NORM_LAT-1][0]) * VEC_W'(r_n[1]);
      y1_p_r[5] <= VEC_W'(dl_f_r[NORM_LAT-1][1]) * VEC_W'(r_n[0]);
      y1_f_r    <= dl_f_r[NORM_LAT-1];
      for (int i = 0; i < 3; i++) y1_r_r[i] <= r_n[i];
      y1_ok_r   <= dl_ok_r[NORM_LAT-1] && r_stat.ok;

      for (int i = 0; i < 3; i++) begin
        y2_u_r[i] <= ud_y2[i][U_W-1:0];
        y3_u_r[i] <= T_W'(y2_u_r[i]);
        y3_f_r[i] <= T_W'(y2_f_r[i]);
        y3_r_r[i] <= T_W'(y2_r_r[i]);
      end
      y2_f_r  <= y1_f_r;
      y2_r_r  <= y1_r_r;
      y2_ok_r <= y1_ok_r;

      y3_t_r  <= t_y3;
      y3_br_r <= br_y3;
      y3_ok_r <= y2_ok_r;

      for (int i = 0; i < NLANE; i++) y4_qv_r[i] <= VEC_W'(qv_y4[i]);
      y4_ok_r <= y3_ok_r;
    end
  end

  stat_t q_stat;
  nq_t   q_n [NLANE];

  lrq_norm u_norm_q (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_vld(y4_vld_r),
    .fb    (FB_W'(QUAT_FRAC_BITS)),
    .vin   (y4_qv_r),
    .stat  (q_stat),
    .qout  (q_n)
  );

  logic dq_ok_r [NORM_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      dq_ok_r[0] <= y4_ok_r;
      for (int k = 1; k < NORM_LAT; k++) dq_ok_r[k] <= dq_ok_r[k-1];
    end
  end

  // saturate, zero on failure
  logic            ok_z;
  nq_t             sat_z [NLANE];
  logic [OW-1:0]   o_q_r [NLANE];
  logic            o_deg_r;

  always_comb begin
    ok_z = dq_ok_r[NORM_LAT-1] && q_stat.ok;
    for (int i = 0; i < NLANE; i++) begin
      if (!ok_z) begin
        sat_z[i] = '0;
      end else if (q_n[i] > QMAX) begin
        sat_z[i] = QMAX;
      end else if (q_n[i] < QMIN) begin
        sat_z[i] = QMIN;
      end else begin
        sat_z[i] = q_n[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NLANE; i++) o_q_r[i] <= sat_z[i][OW-1:0];
      o_deg_r <= !ok_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r    <= 1'b0;
      x2_vld_r    <= 1'b0;
      y1_vld_r    <= 1'b0;
      y2_vld_r    <= 1'b0;
      y3_vld_r    <= 1'b0;
      y4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      x1_vld_r    <= f_stat.vld;
      x2_vld_r    <= x1_vld_r;
      y1_vld_r    <= r_stat.vld;
      y2_vld_r    <= y1_vld_r;
      y3_vld_r    <= y2_vld_r;
      y4_vld_r    <= y3_vld_r;
      out_valid_r <= q_stat.vld;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_quat_w     = o_q_r[0];
  assign out_quat_x     = o_q_r[1];
  assign out_quat_y     = o_q_r[2];
  assign out_quat_z     = o_q_r[3];
  assign out_degenerate = o_deg_r;

endmodule

@@ src/lrq_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrq_norm: pipelined block-scale and normalize of a four-lane vector
// Scales the largest magnitude into [2^29, 2^30), takes the integer root of
// the sum of squares and divides each lane by it, rounding half away.
// ----------------------------------------------------------------------------
module lrq_norm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [lrq_pkg::FB_W-1:0]   fb,
  input  lrq_pkg::wide_t             vin [lrq_pkg::NLANE],
  output lrq_pkg::stat_t             stat,
  output lrq_pkg::nq_t               qout [lrq_pkg::NLANE]
);
  import lrq_pkg::*;

  // stage A: magnitudes and maximum
  logic [VEC_W-1:0] mag_a [NLANE];
  logic [VEC_W-1:0] m01, m23, mmax;
  wide_t            a_v_r [NLANE];
  logic [VEC_W-1:0] a_m_r;
  logic             a_vld_r;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      mag_a[i] = vin[i][VEC_W-1] ? $unsigned(-vin[i]) : $unsigned(vin[i]);
    end
    m01  = (mag_a[0] > mag_a[1]) ? mag_a[0] : mag_a[1];
    m23  = (mag_a[2] > mag_a[3]) ? mag_a[2] : mag_a[3];
    mmax = (m01 > m23) ? m01 : m23;
  end

  // stage B: shift amount and direction
  logic [SH_W-1:0] lead;
  logic            big_b;
  wide_t           b_v_r [NLANE];
  logic [SH_W-1:0] b_sh_r;
  logic            b_big_r, b_nz_r, b_vld_r;

  always_comb begin
    lead = '0;
    for (int i = 0; i < VEC_W; i++) begin
      if (a_m_r[i]) lead = SH_W'(i);
    end
    big_b = |a_m_r[VEC_W-1:UNIT_BITS];
  end

  // stage C: apply shift
  wide_t sh_c [NLANE];
  cval_t c_c_r [NLANE];
  logic  c_nz_r, c_vld_r;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      sh_c[i] = b_big_r ? (b_v_r[i] >>> b_sh_r) : (b_v_r[i] <<< b_sh_r);
    end
  end

  // stage D: squares
  logic [C_W-1:0]  magc_d [NLANE];
  logic [SQ_W-1:0] d_sq_r [NLANE];
  cval_t           d_c_r [NLANE];
  logic            d_nz_r, d_vld_r;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      magc_d[i] = c_c_r[i][C_W-1] ? $unsigned(-c_c_r[i]) : $unsigned(c_c_r[i]);
    end
  end

  // root pipeline, index 0 is the sum register
  logic [VEC_W-1:0] sq_x_r [SQ_STAGES+1];
  logic [VEC_W-1:0] sq_r_r [SQ_STAGES+1];
  cval_t            sq_c_r [SQ_STAGES+1][NLANE];
  logic             sq_nz_r [SQ_STAGES+1];
  logic             sq_vld_r [SQ_STAGES+1];

  // divider pipeline, index 0 is the numerator register
  logic [LEN_W-1:0] dv_rem_r [DV_STAGES+1][NLANE];
  logic [LEN_W-1:0] dv_lo_r  [DV_STAGES+1][NLANE];
  logic [LEN_W-1:0] dv_q_r   [DV_STAGES+1][NLANE];
  logic             dv_neg_r [DV_STAGES+1][NLANE];
  logic [LEN_W-1:0] dv_len_r [DV_STAGES+1];
  logic             dv_nz_r  [DV_STAGES+1];
  logic             dv_vld_r [DV_STAGES+1];

  logic [LEN_W-1:0] len_p;
  logic [C_W-1:0]   magc_p [NLANE];
  logic [VEC_W-1:0] num_p [NLANE];

  always_comb begin
    len_p = sq_r_r[SQ_STAGES][LEN_W-1:0];
    for (int i = 0; i < NLANE; i++) begin
      magc_p[i] = sq_c_r[SQ_STAGES][i][C_W-1] ? $unsigned(-sq_c_r[SQ_STAGES][i])
                                               : $unsigned(sq_c_r[SQ_STAGES][i]);
      num_p[i]  = (VEC_W'(magc_p[i]) << fb) + VEC_W'(len_p >> 1);
    end
  end

  nq_t  f_q_r [NLANE];
  logic f_nz_r, f_vld_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      a_v_r   <= vin;
      a_m_r   <= mmax;
      b_v_r   <= a_v_r;
      b_big_r <= big_b;
      b_sh_r  <= big_b ? SH_W'(lead - SH_W'(UNIT_BITS - 1))
                       : SH_W'(SH_W'(UNIT_BITS - 1) - lead);
      for (int i = 0; i < NLANE; i++) begin
        c_c_r[i]  <= sh_c[i][C_W-1:0];
        d_c_r[i]  <= c_c_r[i];
        d_sq_r[i] <= SQ_W'(magc_d[i]) * SQ_W'(magc_d[i]);
      end
      sq_x_r[0] <= VEC_W'(d_sq_r[0]) + VEC_W'(d_sq_r[1])
                 + VEC_W'(d_sq_r[2]) + VEC_W'(d_sq_r[3]);
      sq_r_r[0] <= '0;
      sq_c_r[0] <= d_c_r;
      dv_len_r[0] <= len_p;
      for (int i = 0; i < NLANE; i++) begin
        dv_rem_r[0][i] <= num_p[i][VEC_W-1:LEN_W];
        dv_lo_r[0][i]  <= num_p[i][LEN_W-1:0];
        dv_q_r[0][i]   <= '0;
        dv_neg_r[0][i] <= sq_c_r[SQ_STAGES][i][C_W-1];
        f_q_r[i] <= dv_neg_r[DV_STAGES][i] ? -$signed(dv_q_r[DV_STAGES][i])
                                           : $signed(dv_q_r[DV_STAGES][i]);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      sq_vld_r[0] <= 1'b0;
      dv_vld_r[0] <= 1'b0;
      f_vld_r     <= 1'b0;
    end else if (en) begin
      a_vld_r     <= in_vld;
      b_vld_r     <= a_vld_r;
      c_vld_r     <= b_vld_r;
      d_vld_r     <= c_vld_r;
      sq_vld_r[0] <= d_vld_r;
      dv_vld_r[0] <= sq_vld_r[SQ_STAGES];
      f_vld_r     <= dv_vld_r[DV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_nz_r      <= |a_m_r;
      c_nz_r      <= b_nz_r;
      d_nz_r      <= c_nz_r;
      sq_nz_r[0]  <= d_nz_r;
      dv_nz_r[0]  <= sq_nz_r[SQ_STAGES];
      f_nz_r      <= dv_nz_r[DV_STAGES];
    end
  end

  // digit-by-digit integer root, two result bits per stage
  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_root
    logic [VEC_W-1:0] x_t, r_t, bit_v;

    always_comb begin
      x_t = sq_x_r[g];
      r_t = sq_r_r[g];
      for (int j = 0; j < SQ_PER; j++) begin
        bit_v = VEC_W'(1) << (VEC_W - 2 - 2 * (g * SQ_PER + j));
        if (x_t >= r_t + bit_v) begin
          x_t = x_t - (r_t + bit_v);
          r_t = (r_t >> 1) + bit_v;
        end else begin
          r_t = r_t >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_x_r[g+1]  <= x_t;
        sq_r_r[g+1]  <= r_t;
        sq_c_r[g+1]  <= sq_c_r[g];
        sq_nz_r[g+1] <= sq_nz_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[g+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[g+1] <= sq_vld_r[g];
      end
    end
  end

  // restoring divide, four quotient bits per stage
  for (genvar g = 0; g < DV_STAGES; g++) begin : g_div
    logic [LEN_W-1:0] rem_t [NLANE];
    logic [LEN_W-1:0] lo_t  [NLANE];
    logic [LEN_W-1:0] q_t   [NLANE];
    logic [LEN_W:0]   trial [NLANE];

    always_comb begin
      for (int i = 0; i < NLANE; i++) begin
        rem_t[i] = dv_rem_r[g][i];
        lo_t[i]  = dv_lo_r[g][i];
        q_t[i]   = dv_q_r[g][i];
        trial[i] = '0;
        for (int j = 0; j < DV_PER; j++) begin
          trial[i] = {rem_t[i], lo_t[i][LEN_W-1]};
          lo_t[i]  = lo_t[i] << 1;
          if (trial[i] >= {1'b0, dv_len_r[g]}) begin
            trial[i] = trial[i] - {1'b0, dv_len_r[g]};
            q_t[i]   = {q_t[i][LEN_W-2:0], 1'b1};
          end else begin
            q_t[i]   = {q_t[i][LEN_W-2:0], 1'b0};
          end
          rem_t[i] = trial[i][LEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[g+1] <= rem_t;
        dv_lo_r[g+1]  <= lo_t;
        dv_q_r[g+1]   <= q_t;
        dv_neg_r[g+1] <= dv_neg_r[g];
        dv_len_r[g+1] <= dv_len_r[g];
        dv_nz_r[g+1]  <= dv_nz_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[g+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[g+1] <= dv_vld_r[g];
      end
    end
  end

  assign stat.vld = f_vld_r;
  assign stat.ok  = f_nz_r;
  assign qout     = f_q_r;

endmodule

@@ src/lrq_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrq_chk: port-level checks for the look rotation quaternion block
// Watches the handshakes and the result fields over time.
// ----------------------------------------------------------------------------
module lrq_chk (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic signed [lrq_pkg::COORD_WIDTH-1:0] in_fwd_x,
  input  logic signed [lrq_pkg::COORD_WIDTH-1:0] in_fwd_y,
  input  logic signed [lrq_pkg::COORD_WIDTH-1:0] in_fwd_z,
  input  logic signed [lrq_pkg::COORD_WIDTH-1:0] in_up_x,
  input  logic signed [lrq_pkg::COORD_WIDTH-1:0] in_up_y,
  input  logic signed [lrq_pkg::COORD_WIDTH-1:0] in_up_z,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic signed [lrq_pkg::QUAT_FRAC_BITS:0] out_quat_w,
  input  logic signed [lrq_pkg::QUAT_FRAC_BITS:0] out_quat_x,
  input  logic signed [lrq_pkg::QUAT_FRAC_BITS:0] out_quat_y,
  input  logic signed [lrq_pkg::QUAT_FRAC_BITS:0] out_quat_z,
  input  logic                                   out_degenerate
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // input is held back only by a held result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  // degenerate results carry a zero quaternion
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_quat_w == 0 && out_quat_x == 0 && out_quat_y == 0 && out_quat_z == 0)
    else $error("degenerate result not zero");

  // a unit quaternion always has a nonzero component
  a_unit_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      out_quat_w != 0 || out_quat_x != 0 || out_quat_y != 0 || out_quat_z != 0)
    else $error("valid quaternion is zero");

endmodule

bind look_rotation_quaternion lrq_chk u_lrq_chk (.*);
